// ----- hw/rtl/mmcsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmcsr_pkg
// Command codes, CSR addresses and mstatus bit positions for the machine-mode
// CSR file.
// ----------------------------------------------------------------------------
package mmcsr_pkg;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned CMD_WIDTH  = 3;
   localparam int unsigned ADDR_WIDTH = 12;
   localparam int unsigned PRIV_WIDTH = 2;
   localparam int unsigned FCSR_WIDTH = 16;

   // commands
   localparam logic [CMD_WIDTH-1:0] CMD_READ    = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE   = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_TRAP    = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_MRET    = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_SET_MIP = 3'd4;

   // csr addresses
   localparam logic [ADDR_WIDTH-1:0] ADDR_FFLAGS   = 12'h001;
   localparam logic [ADDR_WIDTH-1:0] ADDR_FRM      = 12'h002;
   localparam logic [ADDR_WIDTH-1:0] ADDR_FCSR     = 12'h003;
   localparam logic [ADDR_WIDTH-1:0] ADDR_SATP     = 12'h180;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MSTATUS  = 12'h300;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MIE      = 12'h304;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MTVEC    = 12'h305;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MSCRATCH = 12'h340;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MEPC     = 12'h341;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MCAUSE   = 12'h342;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MTVAL    = 12'h343;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MIP      = 12'h344;

   // privilege levels
   localparam logic [PRIV_WIDTH-1:0] PRIV_USER    = 2'd0;
   localparam logic [PRIV_WIDTH-1:0] PRIV_MACHINE = 2'd3;

   // mstatus bit positions
   localparam int unsigned MSTATUS_MIE_BIT  = 3;
   localparam int unsigned MSTATUS_MPIE_BIT = 7;
   localparam int unsigned MSTATUS_MPP_LO   = 11;
   localparam int unsigned MSTATUS_MPP_HI   = 12;

   // mcause interrupt flag and vector code field
   localparam int unsigned CAUSE_IRQ_BIT  = 31;
   localparam int unsigned CAUSE_CODE_MSB = 7;

   // float csr fields
   localparam int unsigned FFLAGS_MSB = 4;
   localparam int unsigned FRM_LSB    = 5;
   localparam int unsigned FRM_MSB    = 7;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [ADDR_WIDTH-1:0] csr_addr;
      logic [XLEN-1:0]       write_value;
      logic [XLEN-1:0]       write_mask;
      logic                  set_on;
      logic [XLEN-1:0]       trap_pc;
      logic [XLEN-1:0]       trap_cause;
      logic [XLEN-1:0]       trap_value;
      logic [PRIV_WIDTH-1:0] target_priv;
   } req_item_type;

   typedef struct packed {
      logic [XLEN-1:0]       read_data;
      logic                  ok;
      logic [XLEN-1:0]       next_pc;
      logic [PRIV_WIDTH-1:0] priv_out;
      logic                  global_ie;
      logic                  interrupt_pending;
   } rsp_item_type;

endpackage
`default_nettype wire

// ----- hw/rtl/machine_mode_csr_file_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// machine_mode_csr_file_core
// RV32 machine-mode CSR file: read, masked write, mip set/clear, trap entry
// and mret, one command per transaction.
// ----------------------------------------------------------------------------
// One command is accepted per cycle while req_stall is low. The command is
// captured in an input register, the CSR update and the result are formed in
// one pass of logic, and the result is held in an output register until
// taken. The input register lets one more command be accepted while a result
// waits on rsp_stall. All CSRs are flip-flops and are updated at the same
// edge that loads the result register.
module machine_mode_csr_file_core (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   input  wire  logic                               req_valid,
   output logic                                     req_stall,
   input  wire  logic [mmcsr_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  wire  logic [mmcsr_pkg::ADDR_WIDTH-1:0]   req_csr_addr,
   input  wire  logic [mmcsr_pkg::XLEN-1:0]         req_write_value,
   input  wire  logic [mmcsr_pkg::XLEN-1:0]         req_write_mask,
   input  wire  logic                               req_set_on,
   input  wire  logic [mmcsr_pkg::XLEN-1:0]         req_trap_pc,
   input  wire  logic [mmcsr_pkg::XLEN-1:0]         req_trap_cause,
   input  wire  logic [mmcsr_pkg::XLEN-1:0]         req_trap_value,
   input  wire  logic [mmcsr_pkg::PRIV_WIDTH-1:0]   req_target_priv,
   output logic                                     rsp_valid,
   input  wire  logic                               rsp_stall,
   output logic [mmcsr_pkg::XLEN-1:0]               rsp_read_data,
   output logic                                     rsp_ok,
   output logic [mmcsr_pkg::XLEN-1:0]               rsp_next_pc,
   output logic [mmcsr_pkg::PRIV_WIDTH-1:0]         rsp_priv_out,
   output logic                                     rsp_global_ie,
   output logic                                     rsp_interrupt_pending
);
   import mmcsr_pkg::*;

   // pipeline control
   logic         s1_valid_ff, s1_valid_in;
   req_item_type item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         req_accept;
   logic         s1_go;

   // csr state
   logic [FCSR_WIDTH-1:0] fcsr_ff, fcsr_in;
   logic [PRIV_WIDTH-1:0] priv_ff, priv_in;
   logic [XLEN-1:0]       mstatus_ff, mstatus_in;
   logic [XLEN-1:0]       mie_ff, mie_in;
   logic [XLEN-1:0]       mip_ff, mip_in;
   logic [XLEN-1:0]       mtvec_ff, mtvec_in;
   logic [XLEN-1:0]       mepc_ff, mepc_in;
   logic [XLEN-1:0]       mcause_ff, mcause_in;
   logic [XLEN-1:0]       mtval_ff, mtval_in;
   logic [XLEN-1:0]       mscratch_ff, mscratch_in;
   logic [XLEN-1:0]       satp_ff, satp_in;

   logic [XLEN-1:0] wmask;
   logic [XLEN-1:0] wbits;
   logic [XLEN-1:0] read_val;
   logic            addr_known;
   logic [XLEN-1:0] trap_base;

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);
   end

   assign wmask     = (item_ff.write_mask == '0) ? '1 : item_ff.write_mask;
   assign wbits     = item_ff.write_value & wmask;
   assign trap_base = {mtvec_ff[XLEN-1:1], 1'b0};

   // read mux
   always_comb begin
      read_val   = '0;
      addr_known = 1'b1;
      unique case (item_ff.csr_addr)
         ADDR_FFLAGS:   read_val = {{(XLEN-FFLAGS_MSB-1){1'b0}}, fcsr_ff[FFLAGS_MSB:0]};
         ADDR_FRM:      read_val = {{(XLEN-FRM_MSB+FRM_LSB-1){1'b0}},
                                    fcsr_ff[FRM_MSB:FRM_LSB]};
         ADDR_FCSR:     read_val = {{(XLEN-FCSR_WIDTH){1'b0}}, fcsr_ff};
         ADDR_SATP:     read_val = satp_ff;
         ADDR_MSTATUS:  read_val = mstatus_ff;
         ADDR_MIE:      read_val = mie_ff;
         ADDR_MTVEC:    read_val = mtvec_ff;
         ADDR_MSCRATCH: read_val = mscratch_ff;
         ADDR_MEPC:     read_val = mepc_ff;
         ADDR_MCAUSE:   read_val = mcause_ff;
         ADDR_MTVAL:    read_val = mtval_ff;
         ADDR_MIP:      read_val = mip_ff;
         default:       addr_known = 1'b0;
      endcase
   end

   // state update and result
   always_comb begin
      fcsr_in     = fcsr_ff;
      priv_in     = priv_ff;
      mstatus_in  = mstatus_ff;
      mie_in      = mie_ff;
      mip_in      = mip_ff;
      mtvec_in    = mtvec_ff;
      mepc_in     = mepc_ff;
      mcause_in   = mcause_ff;
      mtval_in    = mtval_ff;
      mscratch_in = mscratch_ff;
      satp_in     = satp_ff;
      rsp_in      = '0;

      unique case (item_ff.cmd)
         CMD_READ: begin
            rsp_in.read_data = read_val;
            rsp_in.ok        = addr_known;
         end
         CMD_WRITE: begin
            rsp_in.ok = addr_known;
            unique case (item_ff.csr_addr)
               ADDR_FFLAGS:   fcsr_in[FFLAGS_MSB:0] = wbits[FFLAGS_MSB:0];
               ADDR_FRM:      fcsr_in[FRM_MSB:FRM_LSB] = wbits[FRM_MSB-FRM_LSB:0];
               ADDR_FCSR:     fcsr_in = (fcsr_ff & ~wmask[FCSR_WIDTH-1:0])
                                        | wbits[FCSR_WIDTH-1:0];
               ADDR_SATP:     satp_in     = (satp_ff & ~wmask) | wbits;
               ADDR_MSTATUS:  mstatus_in  = (mstatus_ff & ~wmask) | wbits;
               ADDR_MIE:      mie_in      = (mie_ff & ~wmask) | wbits;
               ADDR_MTVEC:    mtvec_in    = (mtvec_ff & ~wmask) | wbits;
               ADDR_MSCRATCH: mscratch_in = (mscratch_ff & ~wmask) | wbits;
               ADDR_MEPC:     mepc_in     = (mepc_ff & ~wmask) | wbits;
               ADDR_MCAUSE:   mcause_in   = (mcause_ff & ~wmask) | wbits;
               ADDR_MTVAL:    mtval_in    = (mtval_ff & ~wmask) | wbits;
               ADDR_MIP:      mip_in      = (mip_ff & ~wmask) | wbits;
               default: begin
               end
            endcase
         end
         CMD_TRAP: begin
            mstatus_in[MSTATUS_MPP_HI:MSTATUS_MPP_LO] = priv_ff;
            mstatus_in[MSTATUS_MPIE_BIT]              = mstatus_ff[MSTATUS_MIE_BIT];
            mstatus_in[MSTATUS_MIE_BIT]               = 1'b0;
            mepc_in   = item_ff.trap_pc;
            mcause_in = item_ff.trap_cause;
            mtval_in  = item_ff.trap_value;
            priv_in   = item_ff.target_priv;
            rsp_in.ok = 1'b1;
            // vectored mode applies to interrupts only
            if (mtvec_ff[0] && item_ff.trap_cause[CAUSE_IRQ_BIT]) begin
               rsp_in.next_pc = trap_base
                  + {{(XLEN-CAUSE_CODE_MSB-3){1'b0}},
                     item_ff.trap_cause[CAUSE_CODE_MSB:0], 2'b00};
            end else begin
               rsp_in.next_pc = trap_base;
            end
         end
         CMD_MRET: begin
            priv_in = (mstatus_ff[MSTATUS_MPP_HI:MSTATUS_MPP_LO] == PRIV_USER)
                      ? PRIV_USER : PRIV_MACHINE;
            mstatus_in[MSTATUS_MIE_BIT]               = mstatus_ff[MSTATUS_MPIE_BIT];
            mstatus_in[MSTATUS_MPIE_BIT]              = 1'b1;
            mstatus_in[MSTATUS_MPP_HI:MSTATUS_MPP_LO] = PRIV_USER;
            rsp_in.next_pc = mepc_ff;
            rsp_in.ok      = 1'b1;
         end
         CMD_SET_MIP: begin
            mip_in    = item_ff.set_on ? (mip_ff | item_ff.write_value)
                                       : (mip_ff & ~item_ff.write_value);
            rsp_in.ok = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_in.priv_out          = priv_in;
      rsp_in.global_ie         = mstatus_in[MSTATUS_MIE_BIT];
      rsp_in.interrupt_pending = |(mip_in & mie_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fcsr_ff      <= '0;
         priv_ff      <= PRIV_MACHINE;
         mstatus_ff   <= '0;
         mie_ff       <= '0;
         mip_ff       <= '0;
         mtvec_ff     <= '0;
         mepc_ff      <= '0;
         mcause_ff    <= '0;
         mtval_ff     <= '0;
         mscratch_ff  <= '0;
         satp_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            fcsr_ff     <= fcsr_in;
            priv_ff     <= priv_in;
            mstatus_ff  <= mstatus_in;
            mie_ff      <= mie_in;
            mip_ff      <= mip_in;
            mtvec_ff    <= mtvec_in;
            mepc_ff     <= mepc_in;
            mcause_ff   <= mcause_in;
            mtval_ff    <= mtval_in;
            mscratch_ff <= mscratch_in;
            satp_ff     <= satp_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.cmd         <= req_cmd;
         item_ff.csr_addr    <= req_csr_addr;
         item_ff.write_value <= req_write_value;
         item_ff.write_mask  <= req_write_mask;
         item_ff.set_on      <= req_set_on;
         item_ff.trap_pc     <= req_trap_pc;
         item_ff.trap_cause  <= req_trap_cause;
         item_ff.trap_value  <= req_trap_value;
         item_ff.target_priv <= req_target_priv;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_ff.read_data;
   assign rsp_ok                = rsp_ff.ok;
   assign rsp_next_pc           = rsp_ff.next_pc;
   assign rsp_priv_out          = rsp_ff.priv_out;
   assign rsp_global_ie         = rsp_ff.global_ie;
   assign rsp_interrupt_pending = rsp_ff.interrupt_pending;

   // reported status matches the registers it was taken from
   a_status_tracks_state: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (rsp_priv_out == priv_ff)
                && (rsp_global_ie == mstatus_ff[MSTATUS_MIE_BIT])
                && (rsp_interrupt_pending == (|(mip_ff & mie_ff))))
      else $error("result status differs from csr state");

   // trap entry leaves machine interrupts disabled and saves the old privilege
   a_trap_entry: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (item_ff.cmd == CMD_TRAP))
      |=> !mstatus_ff[MSTATUS_MIE_BIT]
          && (mstatus_ff[MSTATUS_MPP_HI:MSTATUS_MPP_LO] == $past(priv_ff)))
      else $error("trap entry did not update mstatus");

   // mret clears mpp and sets mpie
   a_mret_exit: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (item_ff.cmd == CMD_MRET))
      |=> mstatus_ff[MSTATUS_MPIE_BIT]
          && (mstatus_ff[MSTATUS_MPP_HI:MSTATUS_MPP_LO] == PRIV_USER))
      else $error("mret did not restore mstatus");

   // a held input transaction only waits on a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
